/* rtl/core/oale_pkg.sv */
// Shared field widths, operation and status codes, and controller-datapath signal groups.
package oale_pkg;

   localparam int OP_W   = 3;
   localparam int VAL_W  = 32;
   localparam int POS_W  = 8;
   localparam int STAT_W = 2;
   localparam int IDX_W  = 6;
   localparam int CNT_W  = 7;

   localparam logic [OP_W-1:0] OP_APPEND    = 3'd0;
   localparam logic [OP_W-1:0] OP_INSERT    = 3'd1;
   localparam logic [OP_W-1:0] OP_DEL_VALUE = 3'd2;
   localparam logic [OP_W-1:0] OP_DEL_POS   = 3'd3;
   localparam logic [OP_W-1:0] OP_TRAVERSE  = 3'd4;

   localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
   localparam logic [STAT_W-1:0] ST_BAD       = 2'd1;
   localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd3;

   typedef struct packed {
      logic edit;
      logic step;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic start_scan;
      logic scan_trav;
      logic last;
   } stat_type;

endpackage

/* rtl/core/oale_dp.sv */
// Datapath: list cells, entry count, rotating scan unit and result register.
module oale_dp #(
   parameter int DEPTH = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  oale_pkg::cmd_type              cmd,
   output oale_pkg::stat_type             stat,
   input  logic [oale_pkg::OP_W-1:0]      req_op,
   input  logic [oale_pkg::VAL_W-1:0]     req_value,
   input  logic [oale_pkg::POS_W-1:0]     req_pos,
   output logic [oale_pkg::STAT_W-1:0]    res_status,
   output logic [oale_pkg::VAL_W-1:0]     res_element,
   output logic [oale_pkg::IDX_W-1:0]     res_index,
   output logic [oale_pkg::CNT_W-1:0]     res_count,
   output logic                           res_last
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = $clog2(DEPTH);

   logic [oale_pkg::VAL_W-1:0] slot_ff [DEPTH];
   logic [oale_pkg::VAL_W-1:0] slot_in [DEPTH];
   logic [oale_pkg::VAL_W-1:0] up      [DEPTH];
   logic [oale_pkg::VAL_W-1:0] down    [DEPTH];

   logic [CW-1:0]              count_ff, count_in;
   logic [CW-1:0]              len_ff, len_in;
   logic [SW-1:0]              step_ff, step_in;
   logic                       found_ff, found_in;
   logic [oale_pkg::OP_W-1:0]  op_ff, op_in;
   logic [oale_pkg::VAL_W-1:0] value_ff, value_in;

   logic [oale_pkg::STAT_W-1:0] status_ff, status_in;
   logic [oale_pkg::VAL_W-1:0]  element_ff, element_in;
   logic [oale_pkg::IDX_W-1:0]  index_ff, index_in;
   logic [oale_pkg::CNT_W-1:0]  rcount_ff, rcount_in;
   logic                        last_ff, last_in;

   logic [CW-1:0]              cm1;
   logic [oale_pkg::POS_W-1:0] cnt8;
   logic [oale_pkg::VAL_W-1:0] head;
   logic                       full, drop;
   logic                       ok_app, ok_ins, ok_del;
   logic                       list_empty;

   for (genvar g = 0; g < DEPTH; g++) begin : g_nbr
      if (g < DEPTH - 1) begin : g_up
         assign up[g] = slot_ff[g+1];
      end else begin : g_up_end
         assign up[g] = slot_ff[g];
      end
      if (g > 0) begin : g_dn
         assign down[g] = slot_ff[g-1];
      end else begin : g_dn_end
         assign down[g] = slot_ff[g];
      end
   end

   assign head       = slot_ff[0];
   assign cm1        = count_ff - CW'(1);
   assign cnt8       = oale_pkg::POS_W'(count_ff);
   assign full       = (count_ff == CW'(DEPTH));
   assign list_empty = (count_ff == '0);
   assign ok_app     = (req_op == oale_pkg::OP_APPEND) && !full;
   assign ok_ins     = (req_op == oale_pkg::OP_INSERT) && !full && (req_pos <= cnt8);
   assign ok_del     = (req_op == oale_pkg::OP_DEL_POS) && (req_pos < cnt8);
   assign drop       = (op_ff == oale_pkg::OP_DEL_VALUE) && !found_ff && (head == value_ff);

   assign stat.scan_trav  = (req_op == oale_pkg::OP_TRAVERSE);
   assign stat.start_scan = !list_empty &&
                            ((req_op == oale_pkg::OP_TRAVERSE) ||
                             (req_op == oale_pkg::OP_DEL_VALUE));
   assign stat.last       = (CW'(step_ff) == len_ff - CW'(1));

   always_comb begin
      slot_in    = slot_ff;
      count_in   = count_ff;
      len_in     = len_ff;
      step_in    = step_ff;
      found_in   = found_ff;
      op_in      = op_ff;
      value_in   = value_ff;
      status_in  = status_ff;
      element_in = element_ff;
      index_in   = index_ff;
      rcount_in  = rcount_ff;
      last_in    = last_ff;
      if (cmd.edit) begin
         op_in    = req_op;
         value_in = req_value;
         len_in   = count_ff;
         step_in  = '0;
         found_in = 1'b0;
         for (int i = 0; i < DEPTH; i++) begin
            if (ok_app && (CW'(i) == count_ff)) begin
               slot_in[i] = req_value;
            end else if (ok_ins && (oale_pkg::POS_W'(i) == req_pos)) begin
               slot_in[i] = req_value;
            end else if (ok_ins && (oale_pkg::POS_W'(i) > req_pos)) begin
               slot_in[i] = down[i];
            end else if (ok_del && (oale_pkg::POS_W'(i) >= req_pos)) begin
               slot_in[i] = up[i];
            end
         end
         if (ok_app || ok_ins) begin
            count_in = count_ff + CW'(1);
         end else if (ok_del) begin
            count_in = cm1;
         end
         unique case (req_op)
            oale_pkg::OP_APPEND:    status_in = ok_app ? oale_pkg::ST_OK : oale_pkg::ST_BAD;
            oale_pkg::OP_INSERT:    status_in = ok_ins ? oale_pkg::ST_OK : oale_pkg::ST_BAD;
            oale_pkg::OP_DEL_POS:   status_in = ok_del ? oale_pkg::ST_OK : oale_pkg::ST_BAD;
            oale_pkg::OP_DEL_VALUE: status_in = oale_pkg::ST_NOT_FOUND;
            oale_pkg::OP_TRAVERSE:  status_in = oale_pkg::ST_EMPTY;
            default:                status_in = oale_pkg::ST_BAD;
         endcase
         element_in = '0;
         index_in   = '0;
         rcount_in  = oale_pkg::CNT_W'(count_in);
         last_in    = 1'b1;
      end else if (cmd.step) begin
         for (int i = 0; i < DEPTH; i++) begin
            if (CW'(i) < cm1) begin
               slot_in[i] = up[i];
            end else if ((CW'(i) == cm1) && !drop) begin
               slot_in[i] = head;
            end
         end
         step_in  = step_ff + SW'(1);
         found_in = found_ff | drop;
         if (drop) begin
            count_in = cm1;
         end
         if (op_ff == oale_pkg::OP_TRAVERSE) begin
            status_in  = oale_pkg::ST_OK;
            element_in = head;
            index_in   = oale_pkg::IDX_W'(step_ff);
            rcount_in  = oale_pkg::CNT_W'(count_ff);
            last_in    = stat.last;
         end else begin
            status_in  = found_in ? oale_pkg::ST_OK : oale_pkg::ST_NOT_FOUND;
            element_in = '0;
            index_in   = '0;
            rcount_in  = oale_pkg::CNT_W'(count_in);
            last_in    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff  <= slot_in;
      len_ff   <= len_in;
      step_ff  <= step_in;
      found_ff <= found_in;
      op_ff    <= op_in;
      value_ff <= value_in;
      if (cmd.load_rsp) begin
         status_ff  <= status_in;
         element_ff <= element_in;
         index_ff   <= index_in;
         rcount_ff  <= rcount_in;
         last_ff    <= last_in;
      end
   end

   assign res_status  = status_ff;
   assign res_element = element_ff;
   assign res_index   = index_ff;
   assign res_count   = rcount_ff;
   assign res_last    = last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count beyond depth");

   a_drop_shrinks: assert property (@(posedge clock) disable iff (reset)
      (cmd.step && drop) |=> (count_ff == $past(count_ff) - CW'(1)))
      else $error("match removal did not shrink the list");

endmodule

/* rtl/core/oale_ctrl.sv */
// Controller: request/result handshakes and the scan sequencer state machine.
module oale_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output oale_pkg::cmd_type   cmd,
   input  oale_pkg::stat_type  stat
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_TRAV = 3'b010,
      ST_DEL  = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = out_free;
            if (req_tvalid && out_free) begin
               cmd.edit = 1'b1;
               if (stat.start_scan) begin
                  state_in = stat.scan_trav ? ST_TRAV : ST_DEL;
               end else begin
                  cmd.load_rsp = 1'b1;
               end
            end
         end
         ST_TRAV: begin
            if (out_free) begin
               cmd.step     = 1'b1;
               cmd.load_rsp = 1'b1;
               if (stat.last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_DEL: begin
            if (!stat.last || out_free) begin
               cmd.step = 1'b1;
               if (stat.last) begin
                  cmd.load_rsp = 1'b1;
                  state_in     = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.load_rsp || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> (state_ff == ST_IDLE))
      else $error("request taken outside idle");

   a_edit_result: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && !stat.start_scan) |=> rsp_valid_ff)
      else $error("edit gave no result");

   a_scan_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE && stat.last && cmd.step) |=> (state_ff == ST_IDLE && rsp_valid_ff))
      else $error("scan did not finish with a result");

endmodule

/* rtl/core/ordered_array_list_editor.sv */
// Top level of the ordered array list editor: stream ports, field packing, controller and datapath.
//
//  channel  dir  handshake              payload
//  req      in   req_tvalid/req_tready  req_tdata: op, value, position
//  rsp      out  rsp_tvalid/rsp_tready  rsp_tdata: status, element, index, count; rsp_tlast
//
//  Append, insert, delete at position, bad ops, empty-list scans: done on taking the request; cells shift at once.
//  Traverse: after the request is taken, one result per entry; the list rotates and is restored.
//  Delete by value: after the request is taken, one compare per entry, one compare per cycle while not stalled.
//  A request is taken only between items, and only when the result register is free.
//  A held result stalls traverse steps and the last delete-by-value step.
//  Reset clears the count and control only; cells need no clearing.
module ordered_array_list_editor #(
   parameter int DEPTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // op[2:0], value[34:3], position[42:35], zero[47:43]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // status[1:0], element[33:2], index[39:34], count[46:40], zero[47]
   output logic        rsp_tlast
);

   oale_pkg::cmd_type  cmd;
   oale_pkg::stat_type stat;

   logic [oale_pkg::OP_W-1:0]   req_op;
   logic [oale_pkg::VAL_W-1:0]  req_value;
   logic [oale_pkg::POS_W-1:0]  req_pos;
   logic [oale_pkg::STAT_W-1:0] res_status;
   logic [oale_pkg::VAL_W-1:0]  res_element;
   logic [oale_pkg::IDX_W-1:0]  res_index;
   logic [oale_pkg::CNT_W-1:0]  res_count;

   assign req_op    = req_tdata[2:0];
   assign req_value = req_tdata[34:3];
   assign req_pos   = req_tdata[42:35];

   assign rsp_tdata = {1'b0, res_count, res_index, res_element, res_status};

   oale_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

   oale_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .req_op      (req_op),
      .req_value   (req_value),
      .req_pos     (req_pos),
      .res_status  (res_status),
      .res_element (res_element),
      .res_index   (res_index),
      .res_count   (res_count),
      .res_last    (rsp_tlast)
   );

endmodule
